/* rtl/rscnp_pkg.sv */
// ----------------------------------------------------------------------------
// rscnp_pkg: shared types and constants of the range scan cluster unit
// Scan geometry, field widths, register indexes and the result beat types.
// ----------------------------------------------------------------------------
package rscnp_pkg;

    // Scan geometry.
    localparam int SECTOR_SAMPLES = 24;
    localparam int SECTOR_COUNT   = 16;
    localparam int SCAN_TOTAL     = SECTOR_SAMPLES * SECTOR_COUNT;

    // Counter widths follow from the geometry.
    localparam int POS_W    = (SCAN_TOTAL > 1) ? $clog2(SCAN_TOTAL) : 1;
    localparam int SAMPLE_W = (SECTOR_SAMPLES > 1) ? $clog2(SECTOR_SAMPLES) : 1;

    // Field widths.
    localparam int DIST_W  = 16;
    localparam int INDEX_W = 9;
    localparam int COUNT_W = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_THRESHOLD   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CLUSTER_SIZE = 8'd1;
    localparam logic [DIST_W-1:0]      JUMP_THRESHOLD_RST   = 16'd30;
    localparam logic [COUNT_W-1:0]     MIN_CLUSTER_SIZE_RST = 4'd4;

    // Output queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [INDEX_W-1:0] point_index;
        logic               last_of_run;
    } result_t;

    // Up to two results produced by one sample, in emission order.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

/* rtl/rscnp_seg.sv */
// ----------------------------------------------------------------------------
// rscnp_seg: cluster segmentation core
// Holds the scan and cluster state and turns one sample into zero to two
// closed-cluster results combinationally.
// ----------------------------------------------------------------------------
module rscnp_seg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic [rscnp_pkg::DIST_W-1:0]     distance,
    input  logic [rscnp_pkg::DIST_W-1:0]     jump_threshold,
    input  logic [rscnp_pkg::COUNT_W-1:0]    min_cluster_size,
    output rscnp_pkg::push_t                 push
);

    logic [rscnp_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [rscnp_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                           open_reg, open_next;
    logic [rscnp_pkg::DIST_W-1:0]   last_dist_reg, last_dist_next;
    logic [rscnp_pkg::INDEX_W-1:0]  first_idx_reg, first_idx_next;
    logic [rscnp_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [rscnp_pkg::DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic [rscnp_pkg::INDEX_W-1:0]  best_idx_reg, best_idx_next;

    logic [rscnp_pkg::INDEX_W-1:0]  idx;
    logic [rscnp_pkg::DIST_W-1:0]   diff;
    logic                           valid_sample;
    logic                           jump;
    logic                           sector_last;
    logic                           open_upd;
    logic                           end_emit;
    logic [rscnp_pkg::INDEX_W-1:0]  chosen_old;
    logic [rscnp_pkg::INDEX_W-1:0]  chosen_new;

    always_comb begin
        idx          = rscnp_pkg::INDEX_W'(pos_reg);
        diff         = (distance > last_dist_reg) ? (distance - last_dist_reg)
                                                  : (last_dist_reg - distance);
        valid_sample = (distance != '0);
        jump         = advance && valid_sample && open_reg && (diff > jump_threshold);
        sector_last  = (sample_reg == rscnp_pkg::SAMPLE_W'(rscnp_pkg::SECTOR_SAMPLES - 1));
        chosen_old   = (count_reg < min_cluster_size) ? first_idx_reg : best_idx_reg;

        open_upd       = open_reg;
        last_dist_next = last_dist_reg;
        first_idx_next = first_idx_reg;
        count_next     = count_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        pos_next       = pos_reg;
        sample_next    = sample_reg;

        if (advance) begin
            if (valid_sample) begin
                if (open_reg && !jump) begin
                    if (count_reg != rscnp_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (distance < best_dist_reg) begin
                        best_dist_next = distance;
                        best_idx_next  = idx;
                    end
                end else begin
                    open_upd       = 1'b1;
                    first_idx_next = idx;
                    count_next     = rscnp_pkg::COUNT_W'(1);
                    best_dist_next = distance;
                    best_idx_next  = idx;
                end
                last_dist_next = distance;
            end
            if (pos_reg == rscnp_pkg::POS_W'(rscnp_pkg::SCAN_TOTAL - 1)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            if (sector_last) begin
                sample_next = '0;
            end else begin
                sample_next = sample_reg + 1'b1;
            end
        end

        // The cluster as it stands after this sample closes at the sector end.
        end_emit   = advance && sector_last && open_upd;
        open_next  = open_upd && !(advance && sector_last);
        chosen_new = (count_next < min_cluster_size) ? first_idx_next : best_idx_next;

        push.valid0 = jump || end_emit;
        push.valid1 = jump && end_emit;
        push.res0.point_index = jump ? chosen_old : chosen_new;
        push.res0.last_of_run = !(jump && end_emit);
        push.res1.point_index = chosen_new;
        push.res1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sample_reg    <= '0;
            open_reg      <= 1'b0;
            last_dist_reg <= '0;
            first_idx_reg <= '0;
            count_reg     <= '0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
        end else begin
            pos_reg       <= pos_next;
            sample_reg    <= sample_next;
            open_reg      <= open_next;
            last_dist_reg <= last_dist_next;
            first_idx_reg <= first_idx_next;
            count_reg     <= count_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
        end
    end

    // A second result only comes from a jump on the last sample of a sector.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid1 |-> (push.valid0 && sector_last && advance))
        else $error("second result without jump at sector end");

    // No cluster survives the last sample of a sector.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && sector_last) |=> !open_reg)
        else $error("cluster left open across a sector boundary");

    // An open cluster always has at least one member.
    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (count_reg != '0))
        else $error("open cluster with no members");

endmodule

/* rtl/rscnp_queue.sv */
// ----------------------------------------------------------------------------
// rscnp_queue: result queue
// Small register queue that takes up to two results a cycle and hands one
// beat a cycle to the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module rscnp_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rscnp_pkg::push_t                 push,
    output logic                             has_room,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rscnp_pkg::INDEX_W-1:0]    m_point_index,
    output logic                             m_last_of_run
);

    rscnp_pkg::result_t              entry_reg [rscnp_pkg::QUEUE_DEPTH];
    logic [rscnp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rscnp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rscnp_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [rscnp_pkg::QPTR_W-1:0]    wr_ptr_plus1;
    logic [1:0]                      push_n;
    logic                            pop;

    always_comb begin
        pop          = m_valid && m_ready;
        push_n       = {1'b0, push.valid0} + {1'b0, push.valid1};
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + rscnp_pkg::QPTR_W'(push_n);
        rd_ptr_next  = rd_ptr_reg + rscnp_pkg::QPTR_W'(pop);
        count_next   = count_reg + rscnp_pkg::QCNT_W'(push_n) - rscnp_pkg::QCNT_W'(pop);
        has_room     = (count_reg <= rscnp_pkg::QCNT_W'(rscnp_pkg::QUEUE_DEPTH - 2));
        m_valid      = (count_reg != '0);
        m_point_index = entry_reg[rd_ptr_reg].point_index;
        m_last_of_run = entry_reg[rd_ptr_reg].last_of_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1) begin
            entry_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    // Pushes only arrive when two slots are free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid0 |-> has_room)
        else $error("result pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rscnp_pkg::QCNT_W'(rscnp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // The fill count tracks the pointer distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rscnp_pkg::QPTR_W'(wr_ptr_reg - rd_ptr_reg) == rscnp_pkg::QPTR_W'(count_reg))
        else $error("queue pointers and count disagree");

endmodule

/* rtl/range_scan_cluster_nearest_point_unit.sv */
// ----------------------------------------------------------------------------
// range_scan_cluster_nearest_point_unit: scan breakpoint segmentation
// Splits each sector of a range scan into clusters at distance jumps and
// reports one scan index per closed cluster.
// ----------------------------------------------------------------------------
// Usage: range samples enter on the s_ channel, one beat per sample in scan
// order (24 samples per sector, 16 sectors per scan, then the position wraps).
// A zero sample is invalid but still advances the position. Each sample yields
// zero, one or two result beats on the m_ channel; m_last_of_run marks the
// final beat produced by a sample. Configuration beats on the cfg_ channel
// are always taken and write the jump threshold (index 0) or the minimum
// cluster size (index 1); other indexes are ignored. Change them only while
// the block is idle.
// An accepted sample is held in the input register, then its results pass
// through the segmentation logic into the result queue. The block accepts
// one sample every cycle as long as the four-entry result queue has room for
// two more beats. When the receiver stalls, the queue fills and s_ready
// drops, with one sample held in the input register. Reset clears the scan
// position, the open cluster, the queue and restores both registers to their
// reset values.
// ----------------------------------------------------------------------------
module range_scan_cluster_nearest_point_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rscnp_pkg::DIST_W-1:0]         s_distance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rscnp_pkg::INDEX_W-1:0]        m_point_index,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rscnp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rscnp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                            in_valid_reg;
    logic [rscnp_pkg::DIST_W-1:0]    in_dist_reg;
    logic [rscnp_pkg::DIST_W-1:0]    jump_thr_reg;
    logic [rscnp_pkg::COUNT_W-1:0]   min_size_reg;
    logic                            has_room;
    logic                            advance;
    rscnp_pkg::push_t                push;

    // The held sample is processed whenever the queue can take its results;
    // a new sample may enter in the same cycle.
    assign advance   = in_valid_reg && has_room;
    assign s_ready   = !in_valid_reg || has_room;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            jump_thr_reg <= rscnp_pkg::JUMP_THRESHOLD_RST;
            min_size_reg <= rscnp_pkg::MIN_CLUSTER_SIZE_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    rscnp_pkg::CFG_JUMP_THRESHOLD: begin
                        jump_thr_reg <= cfg_data;
                    end
                    rscnp_pkg::CFG_MIN_CLUSTER_SIZE: begin
                        min_size_reg <= cfg_data[rscnp_pkg::COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Sample payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_dist_reg <= s_distance;
        end
    end

    rscnp_seg u_seg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .distance         (in_dist_reg),
        .jump_threshold   (jump_thr_reg),
        .min_cluster_size (min_size_reg),
        .push             (push)
    );

    rscnp_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .has_room      (has_room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_last_of_run (m_last_of_run)
    );

    // A held sample that cannot advance keeps the input closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && !advance))
        else $error("input stalled without a blocked sample");

    // A stalled sample stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_dist_reg)))
        else $error("blocked sample lost from the input register");

    // Results only appear for processed samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid0 |-> advance)
        else $error("result produced without a sample");

endmodule
